// ===== design/bilinear_layer_engine_macros.svh =====
// Assertion macros for the bilinear layer engine.
// ASSERT_OFF removes every check at once.
`ifndef BILINEAR_LAYER_ENGINE_MACROS_SVH
`define BILINEAR_LAYER_ENGINE_MACROS_SVH
`ifndef ASSERT_OFF
// Implication in the same cycle.
`define BLE_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Implication in the next cycle.
`define BLE_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BLE_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define BLE_ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ===== design/ble_pkg.sv =====
package ble_pkg;

  localparam int INDEX_W     = 12;
  localparam int IN_VALUE_W  = 16;
  localparam int COUNT_W     = 5;
  localparam int RESULT_W    = 16;
  localparam int FEATURE_W   = 4;
  localparam int CFG_INDEX_W = 2;
  localparam int S_DATA_W    = 32;
  localparam int M_DATA_W    = 24;
  localparam int ACC_W       = 64;
  localparam int COUNT_CMP_W = 9;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd16;

  typedef enum logic [2:0] {
    MODE_LOAD_WEIGHT = 3'd0,
    MODE_LOAD_BIAS   = 3'd1,
    MODE_LOAD_ONE    = 3'd2,
    MODE_LOAD_TWO    = 3'd3,
    MODE_COMPUTE     = 3'd4
  } mode_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_IN_ONE = 2'd0,
    REG_IN_TWO = 2'd1,
    REG_OUT    = 2'd2
  } cfg_reg_t;

  // Store write strobes, one per store.
  typedef struct packed {
    logic wr_weight;
    logic wr_bias;
    logic wr_one;
    logic wr_two;
  } wr_cmd_t;

  // One multiply-accumulate step issued to the datapath.
  typedef struct packed {
    logic issue;
    logic first;
    logic last_mac;
    logic last_feat;
  } mac_cmd_t;

  // Last loop index for a count register: zero counts as one, clip at max.
  function automatic logic [COUNT_CMP_W-1:0] count_last(
    input logic [COUNT_W-1:0] count,
    input int                 max_count
  );
    logic [COUNT_CMP_W-1:0] wide;
    logic [COUNT_CMP_W-1:0] lim;
    wide = COUNT_CMP_W'(count);
    lim  = COUNT_CMP_W'(max_count);
    if (count == '0) begin
      return '0;
    end else if (wide > lim) begin
      return lim - COUNT_CMP_W'(1);
    end
    return wide - COUNT_CMP_W'(1);
  endfunction

endpackage

// ===== design/ble_datapath.sv =====
module ble_datapath import ble_pkg::*; #(
  parameter int MAX_IN_ONE  = 16,
  parameter int MAX_IN_TWO  = 16,
  parameter int MAX_OUT     = 16,
  parameter int VALUE_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  wr_cmd_t                       wr,
  input  logic [INDEX_W-1:0]            wr_index,
  input  logic signed [IN_VALUE_W-1:0]  wr_value,
  input  mac_cmd_t                      mac,
  input  logic [((MAX_IN_ONE > 1) ? $clog2(MAX_IN_ONE) : 1)-1:0] rd_one,
  input  logic [((MAX_IN_TWO > 1) ? $clog2(MAX_IN_TWO) : 1)-1:0] rd_two,
  input  logic [((MAX_OUT > 1) ? $clog2(MAX_OUT) : 1)-1:0]       rd_feat,
  input  logic [((MAX_OUT * MAX_IN_ONE * MAX_IN_TWO > 1) ?
                 $clog2(MAX_OUT * MAX_IN_ONE * MAX_IN_TWO) : 1)-1:0] rd_weight,
  output logic                          advance,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [M_DATA_W-1:0]           m_tdata,
  output logic                          m_tlast
);

  localparam int CW1 = (MAX_IN_ONE > 1) ? $clog2(MAX_IN_ONE) : 1;
  localparam int CW2 = (MAX_IN_TWO > 1) ? $clog2(MAX_IN_TWO) : 1;
  localparam int KW  = (MAX_OUT > 1) ? $clog2(MAX_OUT) : 1;
  localparam int WEIGHT_DEPTH = MAX_OUT * MAX_IN_ONE * MAX_IN_TWO;
  localparam int CA  = (WEIGHT_DEPTH > 1) ? $clog2(WEIGHT_DEPTH) : 1;
  localparam int WD  = (WEIGHT_DEPTH < (1 << INDEX_W)) ? WEIGHT_DEPTH : (1 << INDEX_W);
  localparam int MAW = (WD > 1) ? $clog2(WD) : 1;
  localparam int VW  = VALUE_WIDTH;
  localparam int PW  = 2 * VALUE_WIDTH;
  localparam int QW  = 2 * VALUE_WIDTH + 1;
  localparam int SH  = 2 * (VALUE_WIDTH / 2);
  localparam logic [ACC_W-1:0] LIM = ACC_W'(1) << (VALUE_WIDTH - 1);

  // Stores
  logic signed [VW-1:0] weight_mem [WD];
  logic signed [VW-1:0] bias_mem   [MAX_OUT];
  logic signed [VW-1:0] one_mem    [MAX_IN_ONE];
  logic signed [VW-1:0] two_mem    [MAX_IN_TWO];

  logic signed [31:0]   wr_wide;
  logic signed [VW-1:0] wr_val;

  assign wr_wide = 32'(wr_value);
  assign wr_val  = wr_wide[VW-1:0];

  always_ff @(posedge clk) begin
    if (wr.wr_weight && (32'(wr_index) < 32'(WD))) begin
      weight_mem[wr_index[MAW-1:0]] <= wr_val;
    end
    if (wr.wr_bias && (32'(wr_index) < 32'(MAX_OUT))) begin
      bias_mem[wr_index[KW-1:0]] <= wr_val;
    end
    if (wr.wr_one && (32'(wr_index) < 32'(MAX_IN_ONE))) begin
      one_mem[wr_index[CW1-1:0]] <= wr_val;
    end
    if (wr.wr_two && (32'(wr_index) < 32'(MAX_IN_TWO))) begin
      two_mem[wr_index[CW2-1:0]] <= wr_val;
    end
  end

  // Whole pipeline moves only when the output register can take a result.
  assign advance = !m_tvalid || m_tready;

  // Stage 1: registered store reads
  logic                 v1;
  mac_cmd_t             c1;
  logic [KW-1:0]        feat1;
  logic signed [VW-1:0] x1_q, x2_q, w_q, b_q;
  logic                 wz1;

  always_ff @(posedge clk) begin
    if (advance && mac.issue) begin
      w_q  <= weight_mem[rd_weight[MAW-1:0]];
      b_q  <= bias_mem[rd_feat];
      x1_q <= one_mem[rd_one];
      x2_q <= two_mem[rd_two];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      c1    <= mac;
      feat1 <= rd_feat;
      wz1   <= !(32'(rd_weight) < 32'(WD));
    end
  end

  // Stage 2: x1 * x2, bias aligned to the product scale
  logic                 v2;
  mac_cmd_t             c2;
  logic [KW-1:0]        feat2;
  logic signed [PW-1:0] p12;
  logic signed [VW-1:0] w2;
  logic [ACC_W-1:0]     b2;

  // Stage 3: (x1 * x2) * w, split in two halves of the first product
  logic                 v3;
  mac_cmd_t             c3;
  logic [KW-1:0]        feat3;
  logic signed [QW-1:0] plo, phi;
  logic [ACC_W-1:0]     b3;
  logic signed [VW:0]   lo_part;
  logic signed [VW-1:0] hi_part;

  assign lo_part = $signed({1'b0, p12[VW-1:0]});
  assign hi_part = $signed(p12[PW-1:VW]);

  // Stage 4: recombine the halves modulo 2^64
  logic                 v4;
  mac_cmd_t             c4;
  logic [KW-1:0]        feat4;
  logic [ACC_W-1:0]     prod4, b4;

  // Stage 5: accumulator
  logic                 v5;
  logic                 last5;
  logic [KW-1:0]        feat5;
  logic [ACC_W-1:0]     acc;

  // Stage 6: sign and magnitude
  logic                 v6;
  logic                 last6;
  logic [KW-1:0]        feat6;
  logic                 neg6;
  logic [ACC_W-1:0]     mag6;

  always_ff @(posedge clk) begin
    if (advance) begin
      c2    <= c1;
      feat2 <= feat1;
      p12   <= PW'(x1_q) * PW'(x2_q);
      w2    <= wz1 ? '0 : w_q;
      b2    <= ACC_W'(b_q) << SH;

      c3    <= c2;
      feat3 <= feat2;
      plo   <= QW'(lo_part) * QW'(w2);
      phi   <= QW'(hi_part) * QW'(w2);
      b3    <= b2;

      c4    <= c3;
      feat4 <= feat3;
      prod4 <= ACC_W'(plo) + (ACC_W'(phi) << VW);
      b4    <= b3;

      if (v4) begin
        acc   <= (c4.first ? b4 : acc) + prod4;
        feat5 <= feat4;
        last5 <= c4.last_feat;
      end

      neg6  <= acc[ACC_W-1];
      mag6  <= acc[ACC_W-1] ? (ACC_W'(0) - acc) : acc;
      feat6 <= feat5;
      last6 <= last5;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else if (advance) begin
      v1 <= mac.issue;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4 && c4.last_mac;
      v6 <= v5;
    end
  end

  // Truncate toward zero, saturate, restore sign
  logic [ACC_W-1:0] q;
  logic [ACC_W-1:0] sat;
  logic [ACC_W-1:0] signed_sat;
  logic [VW-1:0]    res_vw;
  logic [31:0]      res_wide;
  logic [7:0]       feat_wide;

  always_comb begin
    q = mag6 >> SH;
    if (neg6) begin
      sat        = (q > LIM) ? LIM : q;
      signed_sat = ACC_W'(0) - sat;
    end else begin
      sat        = (q > (LIM - ACC_W'(1))) ? (LIM - ACC_W'(1)) : q;
      signed_sat = sat;
    end
    res_vw    = signed_sat[VW-1:0];
    res_wide  = 32'(res_vw);
    feat_wide = 8'(feat6);
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && v6) begin
      m_tdata <= {{(M_DATA_W - RESULT_W - FEATURE_W){1'b0}},
                  feat_wide[FEATURE_W-1:0], res_wide[RESULT_W-1:0]};
      m_tlast <= last6;
    end
  end

endmodule

// ===== design/ble_ctrl.sv =====
module ble_ctrl import ble_pkg::*; #(
  parameter int MAX_IN_ONE = 16,
  parameter int MAX_IN_TWO = 16,
  parameter int MAX_OUT    = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [2:0]             s_tuser,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [COUNT_W-1:0]     cfg_data,
  output wr_cmd_t                wr,
  output mac_cmd_t               mac,
  output logic [((MAX_IN_ONE > 1) ? $clog2(MAX_IN_ONE) : 1)-1:0] rd_one,
  output logic [((MAX_IN_TWO > 1) ? $clog2(MAX_IN_TWO) : 1)-1:0] rd_two,
  output logic [((MAX_OUT > 1) ? $clog2(MAX_OUT) : 1)-1:0]       rd_feat,
  output logic [((MAX_OUT * MAX_IN_ONE * MAX_IN_TWO > 1) ?
                 $clog2(MAX_OUT * MAX_IN_ONE * MAX_IN_TWO) : 1)-1:0] rd_weight,
  input  logic                   advance
);

  localparam int CW1 = (MAX_IN_ONE > 1) ? $clog2(MAX_IN_ONE) : 1;
  localparam int CW2 = (MAX_IN_TWO > 1) ? $clog2(MAX_IN_TWO) : 1;
  localparam int KW  = (MAX_OUT > 1) ? $clog2(MAX_OUT) : 1;
  localparam int WEIGHT_DEPTH = MAX_OUT * MAX_IN_ONE * MAX_IN_TWO;
  localparam int CA  = (WEIGHT_DEPTH > 1) ? $clog2(WEIGHT_DEPTH) : 1;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t             state;
  logic [COUNT_W-1:0] cnt_one, cnt_two, cnt_out;
  logic [CW1-1:0]     i_cnt;
  logic [CW2-1:0]     j_cnt;
  logic [KW-1:0]      k_cnt;
  logic [CA-1:0]      a_cnt;

  logic [COUNT_CMP_W-1:0] one_last, two_last, out_last;
  logic                   accept, start;
  logic                   last_i, last_j, last_k;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign start     = accept && (s_tuser == MODE_COMPUTE);

  assign one_last = count_last(cnt_one, MAX_IN_ONE);
  assign two_last = count_last(cnt_two, MAX_IN_TWO);
  assign out_last = count_last(cnt_out, MAX_OUT);

  assign last_i = (i_cnt == one_last[CW1-1:0]);
  assign last_j = (j_cnt == two_last[CW2-1:0]);
  assign last_k = (k_cnt == out_last[KW-1:0]);

  always_comb begin
    wr = '0;
    if (accept) begin
      unique case (s_tuser)
        MODE_LOAD_WEIGHT: wr.wr_weight = 1'b1;
        MODE_LOAD_BIAS:   wr.wr_bias   = 1'b1;
        MODE_LOAD_ONE:    wr.wr_one    = 1'b1;
        MODE_LOAD_TWO:    wr.wr_two    = 1'b1;
        default:          wr = '0;
      endcase
    end
  end

  always_comb begin
    mac.issue     = (state == ST_RUN);
    mac.first     = (i_cnt == '0) && (j_cnt == '0);
    mac.last_mac  = last_i && last_j;
    mac.last_feat = last_k;
  end

  assign rd_one    = i_cnt;
  assign rd_two    = j_cnt;
  assign rd_feat   = k_cnt;
  assign rd_weight = a_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_one <= COUNT_RESET;
      cnt_two <= COUNT_RESET;
      cnt_out <= COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_IN_ONE: cnt_one <= cfg_data;
        REG_IN_TWO: cnt_two <= cfg_data;
        REG_OUT:    cnt_out <= cfg_data;
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      i_cnt <= '0;
      j_cnt <= '0;
      k_cnt <= '0;
      a_cnt <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            state <= ST_RUN;
            i_cnt <= '0;
            j_cnt <= '0;
            k_cnt <= '0;
            a_cnt <= '0;
          end
        end
        ST_RUN: begin
          // Walk j fastest, then i, then feature k; the weight address follows.
          if (advance) begin
            a_cnt <= a_cnt + CA'(1);
            if (last_j) begin
              j_cnt <= '0;
              if (last_i) begin
                i_cnt <= '0;
                if (last_k) begin
                  state <= ST_IDLE;
                end else begin
                  k_cnt <= k_cnt + KW'(1);
                end
              end else begin
                i_cnt <= i_cnt + CW1'(1);
              end
            end else begin
              j_cnt <= j_cnt + CW2'(1);
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== design/bilinear_layer_engine.sv =====
// Bilinear layer engine: y[k] = x1^T W[k] x2 + b[k] in signed fixed point.
// Input stream (s_*): s_tuser carries the mode (load weight, load bias, load
// first vector, load second vector, compute); s_tdata carries the element
// index and value. Loads are accepted back to back. A compute walks
// out_count * in_one_count * in_two_count multiply-accumulate steps on one
// shared MAC pipeline, one step per cycle while the output is not stalled,
// holding off the input side; the next item is taken as soon as the last step
// is issued. Each feature's result passes the accumulator, sign and output
// registers to m_*, features in ascending order, m_tlast on the final one.
// Products and bias are summed exactly in a 64-bit accumulator, then the sum
// is truncated toward zero to the value scale and saturated.
// Config channel (cfg_*): index 0 in_one_count, 1 in_two_count, 2 out_count;
// always ready; write only while no compute is in flight.
// Reset clears the controller and pipeline valids and sets every count to 16;
// the stores hold garbage until loaded.
// When the receiver holds m_tready low with a result waiting, the whole MAC
// pipeline freezes in place and resumes without loss once the result is taken.
`include "bilinear_layer_engine_macros.svh"

module bilinear_layer_engine import ble_pkg::*; #(
  parameter int MAX_IN_ONE  = 16,
  parameter int MAX_IN_TWO  = 16,
  parameter int MAX_OUT     = 16,
  parameter int VALUE_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [S_DATA_W-1:0]    s_tdata,   // index[11:0], value[27:12], zero[31:28]
  input  logic [2:0]             s_tuser,   // mode[2:0]
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [M_DATA_W-1:0]    m_tdata,   // result_value[15:0], feature_index[19:16], zero
  output logic                   m_tlast,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [COUNT_W-1:0]     cfg_data
);

  localparam int CW1 = (MAX_IN_ONE > 1) ? $clog2(MAX_IN_ONE) : 1;
  localparam int CW2 = (MAX_IN_TWO > 1) ? $clog2(MAX_IN_TWO) : 1;
  localparam int KW  = (MAX_OUT > 1) ? $clog2(MAX_OUT) : 1;
  localparam int WEIGHT_DEPTH = MAX_OUT * MAX_IN_ONE * MAX_IN_TWO;
  localparam int CA  = (WEIGHT_DEPTH > 1) ? $clog2(WEIGHT_DEPTH) : 1;

  // Unpack the request payload
  logic [INDEX_W-1:0]           in_index;
  logic signed [IN_VALUE_W-1:0] in_value;

  assign in_index = s_tdata[INDEX_W-1:0];
  assign in_value = $signed(s_tdata[INDEX_W+IN_VALUE_W-1:INDEX_W]);

  wr_cmd_t        wr;
  mac_cmd_t       mac;
  logic [CW1-1:0] rd_one;
  logic [CW2-1:0] rd_two;
  logic [KW-1:0]  rd_feat;
  logic [CA-1:0]  rd_weight;
  logic           advance;

  ble_ctrl #(
    .MAX_IN_ONE (MAX_IN_ONE),
    .MAX_IN_TWO (MAX_IN_TWO),
    .MAX_OUT    (MAX_OUT)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tuser   (s_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .wr        (wr),
    .mac       (mac),
    .rd_one    (rd_one),
    .rd_two    (rd_two),
    .rd_feat   (rd_feat),
    .rd_weight (rd_weight),
    .advance   (advance)
  );

  ble_datapath #(
    .MAX_IN_ONE  (MAX_IN_ONE),
    .MAX_IN_TWO  (MAX_IN_TWO),
    .MAX_OUT     (MAX_OUT),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .wr        (wr),
    .wr_index  (in_index),
    .wr_value  (in_value),
    .mac       (mac),
    .rd_one    (rd_one),
    .rd_two    (rd_two),
    .rd_feat   (rd_feat),
    .rd_weight (rd_weight),
    .advance   (advance),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  // A compute request makes the input side busy in the next cycle.
  `BLE_ASSERT_NXT(a_compute_busy, clk, rst, s_tvalid && s_tready && (s_tuser == MODE_COMPUTE), !s_tready, "compute request did not occupy the engine")
  // MAC steps are issued only while requests are held off.
  `BLE_ASSERT_IMP(a_issue_busy, clk, rst, mac.issue, !s_tready, "MAC step issued while accepting requests")
  // A waiting result freezes the pipeline.
  `BLE_ASSERT_IMP(a_stall_freeze, clk, rst, m_tvalid && !m_tready, !advance, "pipeline advanced over a stalled result")

endmodule
